>>> rtl/fntc_pkg.sv
// ----------------------------------------------------------------------------
// fntc_pkg: shared types and constants for the synthesizer tuning calculator
// Field widths, band thresholds and the control word that travels down the
// divider cell chain.
// ----------------------------------------------------------------------------
package fntc_pkg;

	localparam int FRACTION_BITS_DEF = 19;
	localparam int CARRIER_BITS = 30;
	localparam int DEV_BITS = 20;
	localparam int CLK_BITS = 25;
	localparam int PFD_BITS = 24;
	localparam int DPROD_BITS = 24;
	localparam int DEVW_BITS = 24;
	localparam int FRACW_BITS = 20;
	localparam int NDIV_BITS = 8;
	localparam int RECIP_BITS = 32;
	localparam int RECIP_SHIFT = 33;

	localparam logic [CLK_BITS-1:0] CLK_RESET = 25'd26000000;
	localparam logic [RECIP_BITS-1:0] RECIP3 = 32'hAAAA_AAAB;

	localparam logic [CARRIER_BITS-1:0] CARRIER_MIN = 30'd142000000;
	localparam logic [CARRIER_BITS-1:0] CARRIER_MAX = 30'd1050000000;
	localparam logic [CARRIER_BITS-1:0] THR_DIV24 = 30'd177000000;
	localparam logic [CARRIER_BITS-1:0] THR_DIV16 = 30'd239000000;
	localparam logic [CARRIER_BITS-1:0] THR_DIV12 = 30'd353000000;
	localparam logic [CARRIER_BITS-1:0] THR_DIV8 = 30'd525000000;
	localparam logic [CARRIER_BITS-1:0] THR_DIV6 = 30'd705000000;

	localparam logic [3:0] BAND_BASE = 4'h8;

	typedef struct packed {
		logic valid;
		logic err;
		logic [4:0] div;
		logic [2:0] band;
	} ctl_t;

endpackage

>>> rtl/fntc_cell.sv
// ----------------------------------------------------------------------------
// fntc_cell: one restoring division step for both dividers
// Takes one dividend bit for the fraction quotient and one for the deviation
// quotient, registers remainders and partial quotients, hands on the operands.
// ----------------------------------------------------------------------------
module fntc_cell #(
	parameter int FRACTION_BITS = fntc_pkg::FRACTION_BITS_DEF,
	parameter int STEPS = fntc_pkg::CARRIER_BITS + fntc_pkg::FRACTION_BITS_DEF,
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  fntc_pkg::ctl_t ctl_i,
	input  logic [fntc_pkg::CARRIER_BITS-1:0] carrier_i,
	input  logic [fntc_pkg::DPROD_BITS-1:0] dprod_i,
	input  logic [fntc_pkg::PFD_BITS-1:0] pfd_i,
	input  logic [fntc_pkg::CLK_BITS-1:0] xclk_i,
	input  logic [fntc_pkg::PFD_BITS-1:0] rs_i,
	input  logic [FRACTION_BITS+7:0] qs_i,
	input  logic [fntc_pkg::CLK_BITS-1:0] rd_i,
	input  logic [fntc_pkg::DEVW_BITS-1:0] qd_i,
	input  logic sat_i,
	output fntc_pkg::ctl_t ctl_q,
	output logic [fntc_pkg::CARRIER_BITS-1:0] carrier_q,
	output logic [fntc_pkg::DPROD_BITS-1:0] dprod_q,
	output logic [fntc_pkg::PFD_BITS-1:0] pfd_q,
	output logic [fntc_pkg::CLK_BITS-1:0] xclk_q,
	output logic [fntc_pkg::PFD_BITS-1:0] rs_q,
	output logic [FRACTION_BITS+7:0] qs_q,
	output logic [fntc_pkg::CLK_BITS-1:0] rd_q,
	output logic [fntc_pkg::DEVW_BITS-1:0] qd_q,
	output logic sat_q
);
	localparam int P = STEPS - 1 - IDX;
	localparam int QW = FRACTION_BITS + 8;

	logic bs, bd, ges, ged;
	logic [fntc_pkg::PFD_BITS:0] rs1;
	logic [fntc_pkg::CLK_BITS:0] rd1;

	generate
		if (P >= FRACTION_BITS) begin : g_bs
			assign bs = carrier_i[P-FRACTION_BITS];
		end else begin : g_bs0
			assign bs = 1'b0;
		end
		if (P >= FRACTION_BITS && P - FRACTION_BITS < fntc_pkg::DPROD_BITS) begin : g_bd
			assign bd = dprod_i[P-FRACTION_BITS];
		end else begin : g_bd0
			assign bd = 1'b0;
		end
	endgenerate

	assign rs1 = {rs_i, bs};
	assign rd1 = {rd_i, bd};
	assign ges = rs1 >= {1'b0, pfd_i};
	assign ged = rd1 >= {1'b0, xclk_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carrier_q <= carrier_i;
			dprod_q <= dprod_i;
			pfd_q <= pfd_i;
			xclk_q <= xclk_i;
			rs_q <= ges ? fntc_pkg::PFD_BITS'(rs1 - {1'b0, pfd_i})
				: fntc_pkg::PFD_BITS'(rs1);
			rd_q <= ged ? fntc_pkg::CLK_BITS'(rd1 - {1'b0, xclk_i})
				: fntc_pkg::CLK_BITS'(rd1);
			qs_q <= {qs_i[QW-2:0], ges};
			qd_q <= {qd_i[fntc_pkg::DEVW_BITS-2:0], ged};
			sat_q <= sat_i | qd_i[fntc_pkg::DEVW_BITS-1];
		end
	end

endmodule

>>> rtl/frac_n_synth_tuning_calc_core.sv
// ----------------------------------------------------------------------------
// frac_n_synth_tuning_calc_core: synthesizer divider and deviation calculator
// Pipeline: the input registers, then the chain of one-bit division cells,
//   then the output register that holds the output word.
// Throughput: one word per cycle; the whole pipe advances together and
//   holds while the output word is stalled.
// Reset: clears all valid bits; crystal clock register returns to 26 MHz.
// ----------------------------------------------------------------------------
module frac_n_synth_tuning_calc_core #(
	parameter int FRACTION_BITS = fntc_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fntc_pkg::CLK_BITS-1:0] crystal_clock_hz,
	input  logic in_valid,
	output logic in_stall,
	input  logic [fntc_pkg::CARRIER_BITS-1:0] carrier_hz,
	input  logic [fntc_pkg::DEV_BITS-1:0] freq_dev,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] band_word,
	output logic [4:0] output_divider,
	output logic [fntc_pkg::NDIV_BITS-1:0] integer_divide,
	output logic [fntc_pkg::FRACW_BITS-1:0] fraction_word,
	output logic [fntc_pkg::DEVW_BITS-1:0] deviation_word,
	output logic range_error
);
	localparam int STEPS = fntc_pkg::CARRIER_BITS + FRACTION_BITS;
	localparam int QW = FRACTION_BITS + 8;
	localparam int PW = fntc_pkg::CLK_BITS + fntc_pkg::RECIP_BITS;

	logic [fntc_pkg::CLK_BITS-1:0] xtal_q;
	logic en;

	fntc_pkg::ctl_t ctl_in, ctl_s1, ctl_s2, ctl_h;
	logic [4:0] div_c;
	logic [2:0] band_c;
	logic [fntc_pkg::CLK_BITS-1:0] x_c;
	logic div3_c;

	logic [fntc_pkg::CARRIER_BITS-1:0] carrier_s1, carrier_s2;
	logic [fntc_pkg::DPROD_BITS-1:0] dprod_s1, dprod_s2;
	logic [fntc_pkg::CLK_BITS-1:0] x_s1, x_s2, xtal_s1, xtal_s2;
	logic div3_s1, div3_s2;
	logic [PW-1:0] prod_s2;
	logic [fntc_pkg::PFD_BITS-1:0] pfd_h;

	fntc_pkg::ctl_t ctl_c [0:STEPS];
	logic [fntc_pkg::CARRIER_BITS-1:0] carrier_c [0:STEPS];
	logic [fntc_pkg::DPROD_BITS-1:0] dprod_c [0:STEPS];
	logic [fntc_pkg::PFD_BITS-1:0] pfd_c [0:STEPS];
	logic [fntc_pkg::CLK_BITS-1:0] xclk_c [0:STEPS];
	logic [fntc_pkg::PFD_BITS-1:0] rs_c [0:STEPS];
	logic [QW-1:0] qs_c [0:STEPS];
	logic [fntc_pkg::CLK_BITS-1:0] rd_c [0:STEPS];
	logic [fntc_pkg::DEVW_BITS-1:0] qd_c [0:STEPS];
	logic sat_c [0:STEPS];

	logic [FRACTION_BITS:0] frac_full;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign en = !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q <= fntc_pkg::CLK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			xtal_q <= crystal_clock_hz;
		end
	end

	always_comb begin
		priority if (carrier_hz < fntc_pkg::THR_DIV24) begin
			div_c = 5'd24; band_c = 3'd5; x_c = xtal_q >> 2; div3_c = 1'b1;
		end else if (carrier_hz < fntc_pkg::THR_DIV16) begin
			div_c = 5'd16; band_c = 3'd4; x_c = xtal_q >> 3; div3_c = 1'b0;
		end else if (carrier_hz < fntc_pkg::THR_DIV12) begin
			div_c = 5'd12; band_c = 3'd3; x_c = xtal_q >> 1; div3_c = 1'b1;
		end else if (carrier_hz < fntc_pkg::THR_DIV8) begin
			div_c = 5'd8; band_c = 3'd2; x_c = xtal_q >> 2; div3_c = 1'b0;
		end else if (carrier_hz < fntc_pkg::THR_DIV6) begin
			div_c = 5'd6; band_c = 3'd1; x_c = xtal_q; div3_c = 1'b1;
		end else begin
			div_c = 5'd4; band_c = 3'd0; x_c = xtal_q >> 1; div3_c = 1'b0;
		end
		ctl_in.valid = in_valid;
		ctl_in.err = (carrier_hz < fntc_pkg::CARRIER_MIN)
			|| (carrier_hz > fntc_pkg::CARRIER_MAX);
		ctl_in.div = div_c;
		ctl_in.band = band_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carrier_s1 <= carrier_hz;
			dprod_s1 <= fntc_pkg::DPROD_BITS'(freq_dev * div_c[4:1]);
			x_s1 <= x_c;
			xtal_s1 <= xtal_q;
			div3_s1 <= div3_c;
			carrier_s2 <= carrier_s1;
			dprod_s2 <= dprod_s1;
			x_s2 <= x_s1;
			xtal_s2 <= xtal_s1;
			div3_s2 <= div3_s1;
			prod_s2 <= PW'(x_s1) * PW'(fntc_pkg::RECIP3);
		end
	end

	always_comb begin
		pfd_h = div3_s2 ? prod_s2[fntc_pkg::RECIP_SHIFT +: fntc_pkg::PFD_BITS]
			: x_s2[fntc_pkg::PFD_BITS-1:0];
		ctl_h = ctl_s2;
		ctl_h.err = ctl_s2.err || (pfd_h == '0);
	end

	assign ctl_c[0] = ctl_h;
	assign carrier_c[0] = carrier_s2;
	assign dprod_c[0] = dprod_s2;
	assign pfd_c[0] = pfd_h;
	assign xclk_c[0] = xtal_s2;
	assign rs_c[0] = '0;
	assign qs_c[0] = '0;
	assign rd_c[0] = '0;
	assign qd_c[0] = '0;
	assign sat_c[0] = 1'b0;

	generate
		for (genvar i = 0; i < STEPS; i++) begin : g_cell
			fntc_cell #(
				.FRACTION_BITS(FRACTION_BITS),
				.STEPS(STEPS),
				.IDX(i)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.ctl_i(ctl_c[i]),
				.carrier_i(carrier_c[i]),
				.dprod_i(dprod_c[i]),
				.pfd_i(pfd_c[i]),
				.xclk_i(xclk_c[i]),
				.rs_i(rs_c[i]),
				.qs_i(qs_c[i]),
				.rd_i(rd_c[i]),
				.qd_i(qd_c[i]),
				.sat_i(sat_c[i]),
				.ctl_q(ctl_c[i+1]),
				.carrier_q(carrier_c[i+1]),
				.dprod_q(dprod_c[i+1]),
				.pfd_q(pfd_c[i+1]),
				.xclk_q(xclk_c[i+1]),
				.rs_q(rs_c[i+1]),
				.qs_q(qs_c[i+1]),
				.rd_q(rd_c[i+1]),
				.qd_q(qd_c[i+1]),
				.sat_q(sat_c[i+1])
			);
		end
	endgenerate

	assign frac_full = {1'b1, qs_c[STEPS][FRACTION_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c[STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_c[STEPS].err) begin
				band_word <= '0;
				output_divider <= '0;
				integer_divide <= '0;
				fraction_word <= '0;
				deviation_word <= '0;
				range_error <= 1'b1;
			end else begin
				band_word <= fntc_pkg::BAND_BASE + {1'b0, ctl_c[STEPS].band};
				output_divider <= ctl_c[STEPS].div;
				integer_divide <= qs_c[STEPS][FRACTION_BITS +: 8] - 8'd1;
				fraction_word <= fntc_pkg::FRACW_BITS'(frac_full);
				deviation_word <= sat_c[STEPS] ? '1 : qd_c[STEPS];
				range_error <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> output_divider == '0 && band_word == '0
			&& integer_divide == '0 && fraction_word == '0 && deviation_word == '0)
		else $error("rejected word carries nonzero fields");

	a_div_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> output_divider == 5'd4 || output_divider == 5'd6
			|| output_divider == 5'd8 || output_divider == 5'd12
			|| output_divider == 5'd16 || output_divider == 5'd24)
		else $error("illegal output divider");

	a_band_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> (output_divider == 5'd24) == (band_word == 4'd13)
			&& (output_divider == 5'd4) == (band_word == 4'd8))
		else $error("band word does not match divider");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fraction_word)
			&& $stable(deviation_word))
		else $error("stalled output word changed");

endmodule
